### rtl/core/wpr_pkg.sv
// Package for the weighted-prediction raster decoder: field widths, register map,
// sample size codes and the request/result payload types.
// Self-contained; imported by weighted_pred_raster_decoder.
package wpr_pkg;

    localparam int unsigned SAMPLE_W          = 64;
    localparam int unsigned COEF_W            = 16;
    localparam int unsigned SHIFT_W           = 6;
    localparam int unsigned RWIDTH_W          = 13;
    localparam int unsigned DEF_MAX_ROW_WIDTH = 4096;
    localparam int unsigned APB_ADDR_W        = 5;
    localparam int unsigned APB_DATA_W        = 32;

    // Register index, taken from the word address of the configuration port.
    typedef enum logic [2:0] {
        REG_COEF_N   = 3'd0,
        REG_COEF_NW  = 3'd1,
        REG_COEF_NE  = 3'd2,
        REG_COEF_NN  = 3'd3,
        REG_SHIFT    = 3'd4,
        REG_SIZE     = 3'd5,
        REG_ROW_WIDTH = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        SIZE_8  = 2'd0,
        SIZE_16 = 2'd1,
        SIZE_32 = 2'd2,
        SIZE_64 = 2'd3
    } t_sample_size;

    typedef struct packed {
        logic [SAMPLE_W-1:0] residual;
        logic                last_in_image;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] decoded_sample;
        logic                image_done;
    } t_out_item;

endpackage

### rtl/core/weighted_pred_raster_decoder.sv
// Weighted-prediction raster decoder. Each residual request gives one decoded sample,
// W + residual + K, where K is a weighted, rounded and shifted sum of the samples above
// (N, NW, NE, NN) taken from two line memories of MAX_ROW_WIDTH x 64 bits. A request
// runs through the line memory read, four 64x16 weight multiplies, the weighted sum,
// and the shift with the final add into the output register, each of them registered.
// Requests are taken one per clock while a row holds at least five samples and the
// output is not stalled; on narrower rows a request waits until the samples it reads
// have been written back to the line memory. Configuration is written through the APB
// port at byte address 4*index and may only change while the block is empty. Depends
// on wpr_pkg.
module weighted_pred_raster_decoder
    import wpr_pkg::*;
#(
    parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,

    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int unsigned WID_W = $clog2(MAX_ROW_WIDTH + 1);

    typedef enum logic [1:0] {
        PH_ROW0,
        PH_ROW1,
        PH_ROWN
    } t_phase;

    function automatic t_phase phase_inc(t_phase p);
        case (p)
            PH_ROW0: return PH_ROW1;
            PH_ROW1: return PH_ROWN;
            default: return PH_ROWN;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] size_mask(t_sample_size s);
        case (s)
            SIZE_8:  return SAMPLE_W'(64'h0000_0000_0000_00FF);
            SIZE_16: return SAMPLE_W'(64'h0000_0000_0000_FFFF);
            SIZE_32: return SAMPLE_W'(64'h0000_0000_FFFF_FFFF);
            default: return '1;
        endcase
    endfunction

    // Unsigned sample times sign-extended coefficient, modulo 2^64. The sign of the
    // coefficient is folded in as a subtraction of the sample shifted up by 16.
    function automatic logic [SAMPLE_W-1:0] wmul(logic [SAMPLE_W-1:0] v,
                                                  logic [COEF_W-1:0]   c);
        logic [SAMPLE_W+COEF_W-1:0] prod;
        logic [SAMPLE_W-1:0]        corr;
        prod = v * c;
        corr = c[COEF_W-1] ? (v << COEF_W) : '0;
        return prod[SAMPLE_W-1:0] - corr;
    endfunction

    function automatic logic col_hit(logic v, logic [COL_W-1:0] c, logic [COL_W-1:0] a,
                                     logic ne, logic [COL_W-1:0] b);
        return v && ((c == a) || (ne && (c == b)));
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0]   r_coef_n;
    logic [COEF_W-1:0]   r_coef_nw;
    logic [COEF_W-1:0]   r_coef_ne;
    logic [COEF_W-1:0]   r_coef_nn;
    logic [SHIFT_W-1:0]  r_shift;
    t_sample_size        r_size;
    logic [RWIDTH_W-1:0] r_row_width;
    logic                cfg_we;
    t_reg_idx            cfg_idx;

    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_n    <= '0;
            r_coef_nw   <= '0;
            r_coef_ne   <= '0;
            r_coef_nn   <= '0;
            r_shift     <= '0;
            r_size      <= SIZE_8;
            r_row_width <= RWIDTH_W'(1);
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_COEF_N:    r_coef_n    <= pwdata[COEF_W-1:0];
                REG_COEF_NW:   r_coef_nw   <= pwdata[COEF_W-1:0];
                REG_COEF_NE:   r_coef_ne   <= pwdata[COEF_W-1:0];
                REG_COEF_NN:   r_coef_nn   <= pwdata[COEF_W-1:0];
                REG_SHIFT:     r_shift     <= pwdata[SHIFT_W-1:0];
                REG_SIZE:      r_size      <= t_sample_size'(pwdata[1:0]);
                REG_ROW_WIDTH: r_row_width <= pwdata[RWIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_COEF_N:    prdata = APB_DATA_W'(r_coef_n);
            REG_COEF_NW:   prdata = APB_DATA_W'(r_coef_nw);
            REG_COEF_NE:   prdata = APB_DATA_W'(r_coef_ne);
            REG_COEF_NN:   prdata = APB_DATA_W'(r_coef_nn);
            REG_SHIFT:     prdata = APB_DATA_W'(r_shift);
            REG_SIZE:      prdata = APB_DATA_W'(r_size);
            REG_ROW_WIDTH: prdata = APB_DATA_W'(r_row_width);
            default:       prdata = '0;
        endcase
    end

    // Row width clamped to 1..MAX_ROW_WIDTH.
    logic [31:0]        rw_ext;
    logic [WID_W-1:0]   w_eff;
    logic [SAMPLE_W-1:0] mask;

    always_comb begin
        rw_ext = 32'(r_row_width);
        if (rw_ext == 32'd0) begin
            w_eff = WID_W'(1);
        end else if (rw_ext > 32'(MAX_ROW_WIDTH)) begin
            w_eff = WID_W'(MAX_ROW_WIDTH);
        end else begin
            w_eff = WID_W'(rw_ext);
        end
    end

    assign mask = size_mask(r_size);

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic r_out_valid;
    logic out_free, fire3, en1, en2, en3, hazard, accept;

    assign out_free = !r_out_valid || !i_out_stall;
    assign fire3    = r_v3 && out_free;
    assign en3      = out_free || !r_v3;
    assign en2      = en3 || !r_v2;
    assign en1      = en2 || !r_v1;

    // ------------------------------------------------------------------
    // Request side: column and row phase
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col;
    t_phase           r_phase;
    logic             row_wrap;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] ne_addr;
    logic [WID_W-1:0] c0_inc;
    t_phase           ph0;
    logic             use_ne0;
    logic [COL_W-1:0] n_col;
    t_phase           n_phase;

    logic [COL_W-1:0] r_c1, r_c2, r_c3;

    always_comb begin
        // A width that shrank while idle ends the current row first.
        row_wrap = WID_W'(r_col) >= w_eff;
        c0       = row_wrap ? '0 : r_col;
        ph0      = row_wrap ? phase_inc(r_phase) : r_phase;
        c0_inc   = WID_W'(c0) + WID_W'(1);
        use_ne0  = c0_inc < w_eff;
        ne_addr  = COL_W'(c0_inc);

        if (i_in_data.last_in_image) begin
            n_col   = '0;
            n_phase = PH_ROW0;
        end else if (c0_inc >= w_eff) begin
            n_col   = '0;
            n_phase = phase_inc(ph0);
        end else begin
            n_col   = COL_W'(c0_inc);
            n_phase = ph0;
        end
    end

    // A request may not read a line memory entry that an earlier request still has to
    // write back.
    assign hazard = col_hit(r_v1, r_c1, c0, use_ne0, ne_addr)
                 || col_hit(r_v2, r_c2, c0, use_ne0, ne_addr)
                 || col_hit(r_v3, r_c3, c0, use_ne0, ne_addr);

    assign accept     = i_in_valid && en1 && !hazard;
    assign o_in_stall = !en1 || hazard;

    // ------------------------------------------------------------------
    // Line memories
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_mem_above  [MAX_ROW_WIDTH];
    logic [SAMPLE_W-1:0] r_mem_above2 [MAX_ROW_WIDTH];
    logic [SAMPLE_W-1:0] r_rd_n, r_rd_ne, r_rd_nn;
    logic [SAMPLE_W-1:0] dec;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_n  <= r_mem_above[c0];
            r_rd_ne <= r_mem_above[ne_addr];
        end
        if (fire3) begin
            r_mem_above[r_c3] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_nn <= r_mem_above2[c0];
        end
        if (r_v1 && en2) begin
            r_mem_above2[r_c1] <= r_rd_n;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: weight multiplies
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_res1, r_res2, r_res3;
    logic                r_last1, r_last2, r_last3;
    logic                r_usek1, r_usek2, r_usek3;
    logic                r_usenn1, r_usene1;
    logic [SAMPLE_W-1:0] r_prev_n;
    logic [SAMPLE_W-1:0] n_v, nw_v, ne_v, nn_v;
    logic [SAMPLE_W-1:0] r_p_n, r_p_nw, r_p_ne, r_p_nn;

    always_comb begin
        n_v  = r_rd_n & mask;
        nw_v = (r_c1 != '0) ? (r_prev_n & mask) : '0;
        ne_v = r_usene1 ? (r_rd_ne & mask) : '0;
        nn_v = r_usenn1 ? (r_rd_nn & mask) : '0;
    end

    // ------------------------------------------------------------------
    // Stage 2: weighted sum with rounding
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] rnd;
    logic [SAMPLE_W-1:0] r_acc3;

    assign rnd = (r_shift == '0) ? '0 : (SAMPLE_W'(1) << (r_shift - SHIFT_W'(1)));

    // ------------------------------------------------------------------
    // Stage 3: shift, mask and the running add with the west sample
    // ------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] acc_sh;
    logic [SAMPLE_W-1:0]        k_v, west;
    logic [SAMPLE_W-1:0]        r_west;
    t_out_item                  r_out_data;

    always_comb begin
        acc_sh = $signed(r_acc3) >>> r_shift;
        k_v    = r_usek3 ? (SAMPLE_W'(acc_sh) & mask) : '0;
        west   = (r_c3 != '0) ? r_west : '0;
        dec    = (west + r_res3 + k_v) & mask;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_phase     <= PH_ROW0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col   <= n_col;
                r_phase <= n_phase;
            end
            if (en1) begin
                r_v1 <= accept;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (fire3) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c1     <= c0;
            r_res1   <= i_in_data.residual;
            r_last1  <= i_in_data.last_in_image;
            r_usek1  <= (ph0 != PH_ROW0);
            r_usenn1 <= (ph0 == PH_ROWN);
            r_usene1 <= use_ne0;
        end
        if (r_v1 && en2) begin
            r_prev_n <= r_rd_n;
            r_p_n    <= wmul(n_v,  r_coef_n);
            r_p_nw   <= wmul(nw_v, r_coef_nw);
            r_p_ne   <= wmul(ne_v, r_coef_ne);
            r_p_nn   <= wmul(nn_v, r_coef_nn);
            r_c2     <= r_c1;
            r_res2   <= r_res1;
            r_last2  <= r_last1;
            r_usek2  <= r_usek1;
        end
        if (r_v2 && en3) begin
            r_acc3  <= r_p_n + r_p_nw + r_p_ne + r_p_nn + rnd;
            r_c3    <= r_c2;
            r_res3  <= r_res2;
            r_last3 <= r_last2;
            r_usek3 <= r_usek2;
        end
        if (fire3) begin
            r_west                    <= dec;
            r_out_data.decoded_sample <= dec;
            r_out_data.image_done     <= r_last3;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.last_in_image) |=> (r_col == '0 && r_phase == PH_ROW0))
        else $error("last request did not restart column and row phase");

    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_v1 && r_v2 && r_v3) |-> o_in_stall)
        else $error("request taken while the whole pipeline is blocked");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v3))
        else $error("result appeared without a request in the last stage");

endmodule
